// File: rtl/spm_pkg.sv
`default_nettype none
package spm_pkg;
  localparam int VOICES = 8;
  localparam int VW = 3;
  localparam int BLOCK_LEN = 256;
  localparam int BW = 8;
  localparam int SAMPLE_MEM_DEPTH = 65536;
  localparam int AW = 16;

  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_ONCE  = 3'd1;
  localparam logic [2:0] CMD_LOOP  = 3'd2;
  localparam logic [2:0] CMD_STOP  = 3'd3;
  localparam logic [2:0] CMD_VOL   = 3'd4;
  localparam logic [2:0] CMD_WRITE = 3'd5;

  // One voice table entry.
  typedef struct packed {
    logic [15:0] base;
    logic [15:0] len;
    logic [15:0] pos;
    logic [15:0] restart;
    logic [15:0] gain;
  } voice_t;

  // Voice term floor((s-128)*g/256), returned as 16 bits for a wrapping sum.
  function automatic logic [15:0] voice_term(input logic [7:0] s, input logic [15:0] g);
    logic signed [8:0]  d;
    logic signed [25:0] p;
    begin
      d = $signed({1'b0, s}) - 9'sd128;
      p = 26'(d) * 26'($signed({1'b0, g}));
      voice_term = p[23:8];
    end
  endfunction
endpackage
`default_nettype wire

// File: rtl/sample_playback_mixer.sv
`default_nettype none
// Channel | Direction | Handshake            | Payload
// in_     | input     | in_valid / in_stall  | command, voice, address, length,
//         |           |                      | loop_point, gain, data
// out_    | output    | out_valid / out_stall| mixed_sample, block_end,
//         |           |                      | claimed_voice, claim_failed
// One word is worked on at a time. A tick walks the voices in turn: each voice
// costs a voice-table read, a sample-store read and a write back, all through
// the single read port of each memory. Other known commands pass through S_CMD
// to S_DONE. Reset is synchronous and clears control state and the
// active flags; the voice table entries of inactive voices are rewritten on play,
// so their contents need no clearing. A result waits in the output register
// under out_stall while the next word is worked on; that word's own result then
// waits in S_DONE, with in_stall high, until the output register is free.
module sample_playback_mixer
  import spm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_command,
  input  wire logic [2:0]  in_voice,
  input  wire logic [15:0] in_address,
  input  wire logic [15:0] in_length,
  input  wire logic [15:0] in_loop_point,
  input  wire logic [15:0] in_gain,
  input  wire logic [7:0]  in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_mixed_sample,
  output logic             out_block_end,
  output logic [2:0]       out_claimed_voice,
  output logic             out_claim_failed
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1; // voice entry read issued
  localparam logic [2:0] S_SMP  = 3'd2; // sample read issued
  localparam logic [2:0] S_WB   = 3'd3; // accumulate and write back
  localparam logic [2:0] S_CMD  = 3'd4; // voice read landed; play, volume or write applied
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]    st_r, st_nxt;
  logic [2:0]    cmd_r;
  logic [2:0]    vsel_r;
  logic [15:0]   addr_r, len_r, lp_r, gain_r;
  logic [7:0]    data_r;
  logic [VW-1:0] vi_r;
  logic          last_r;
  logic [15:0]   acc_r;
  logic [BW-1:0] tick_r;
  logic          bend_r;
  logic [VOICES-1:0] act_r, loop_r;
  // Result of the word in progress, moved to the output register when free.
  logic [7:0]    res_mix_r;
  logic          res_bend_r;
  logic [2:0]    res_claimed_r;
  logic          res_failed_r;

  // Voice table and sample store ports.
  logic          vwe;
  logic [VW-1:0] vwaddr, vraddr;
  voice_t        vwdata, vrdata;
  logic          swe;
  logic [AW-1:0] sraddr;
  logic [7:0]    srdata;

  spm_voice_ram u_vram (.clk, .we(vwe), .waddr(vwaddr), .wdata(vwdata),
                        .raddr(vraddr), .rdata(vrdata));
  spm_sample_ram u_sram (.clk, .we(swe), .waddr(addr_r), .wdata(data_r),
                         .raddr(sraddr), .rdata(srdata));

  logic       accept;
  logic       out_take;
  logic       out_load;
  logic       free_any;
  logic [VW-1:0] free_idx;
  logic       plays;
  logic [15:0] term, acc_sum;
  logic signed [16:0] mix;

  assign accept   = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign in_stall = (st_r != S_IDLE);
  // A finished word moves to the output register once that is empty or being taken.
  assign out_load = (st_r == S_DONE) && (!out_valid || !out_stall);

  // Lowest free voice.
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (!act_r[i]) begin
        free_any = 1'b1;
        free_idx = VW'(i);
      end
    end
  end

  assign plays   = act_r[vi_r] && (vrdata.pos < vrdata.len);
  assign sraddr  = vrdata.base + vrdata.pos;
  assign term    = voice_term(srdata, vrdata.gain);
  assign acc_sum = acc_r + (plays ? term : 16'd0);
  assign mix     = $signed({acc_sum[15], acc_sum}) + 17'sd128;

  always_comb begin
    vraddr = vi_r;
    vwe    = 1'b0;
    vwaddr = vi_r;
    vwdata = vrdata;
    swe    = 1'b0;
    st_nxt = st_r;
    case (st_r)
      S_IDLE: begin
        if (accept) begin
          if (in_command == CMD_TICK) vraddr = '0;
          else if (in_command == CMD_ONCE || in_command == CMD_LOOP) vraddr = free_idx;
          else vraddr = in_voice;
          case (in_command)
            CMD_TICK:             st_nxt = S_RD;
            CMD_STOP, CMD_VOL:    st_nxt = S_CMD;
            CMD_ONCE, CMD_LOOP:   st_nxt = S_CMD;
            CMD_WRITE:            st_nxt = S_CMD;
            default:              st_nxt = S_DONE;
          endcase
        end
      end
      S_RD:  st_nxt = S_SMP;
      S_SMP: st_nxt = S_WB;
      S_WB: begin
        vwe = 1'b1;
        vwdata.pos = plays ? vrdata.pos + 16'd1 : vrdata.pos;
        if (bend_r && act_r[vi_r] && vwdata.pos == vrdata.len && loop_r[vi_r]) begin
          vwdata.pos = vrdata.restart;
        end
        vraddr = vi_r + VW'(1);
        st_nxt = last_r ? S_DONE : S_RD;
      end
      S_CMD: begin
        st_nxt = S_DONE;
        case (cmd_r)
          CMD_ONCE, CMD_LOOP: begin
            vwaddr = vi_r;
            vwe = !res_failed_r;
            vwdata.base = addr_r;
            vwdata.len  = len_r;
            vwdata.pos  = '0;
            vwdata.gain = 16'd256;
            if (cmd_r == CMD_LOOP) vwdata.restart = lp_r;
          end
          CMD_VOL: begin
            vwaddr = vsel_r;
            vwe = 1'b1;
            vwdata.gain = gain_r;
          end
          CMD_WRITE: swe = 1'b1;
          default: ;
        endcase
      end
      S_DONE: if (out_load) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      out_valid <= 1'b0;
      act_r <= '0;
      loop_r <= '0;
      tick_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (out_load) out_valid <= 1'b1;
      else if (out_take) out_valid <= 1'b0;
      if (accept) begin
        if (in_command == CMD_TICK) begin
          if (tick_r == BW'(BLOCK_LEN - 1)) tick_r <= '0;
          else tick_r <= tick_r + BW'(1);
        end
        if ((in_command == CMD_ONCE || in_command == CMD_LOOP) && free_any) begin
          act_r[free_idx]  <= 1'b1;
          loop_r[free_idx] <= (in_command == CMD_LOOP);
        end
        if (in_command == CMD_STOP) act_r[in_voice] <= 1'b0;
      end
      // A one-shot voice that has reached its end, on this tick or earlier,
      // is released at the block end.
      if (st_r == S_WB && bend_r && act_r[vi_r] && !loop_r[vi_r] &&
          vwdata.pos == vrdata.len) begin
        act_r[vi_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_command;
      vsel_r <= in_voice;
      addr_r <= in_address;
      len_r  <= in_length;
      lp_r   <= in_loop_point;
      gain_r <= in_gain;
      data_r <= in_data;
      acc_r  <= '0;
      last_r <= 1'b0;
      bend_r <= (in_command == CMD_TICK) && (tick_r == BW'(BLOCK_LEN - 1));
      vi_r   <= (in_command == CMD_TICK) ? '0 : free_idx;
      res_mix_r     <= 8'd128;
      res_bend_r    <= (in_command == CMD_TICK) && (tick_r == BW'(BLOCK_LEN - 1));
      res_claimed_r <= '0;
      res_failed_r  <= 1'b0;
      if (in_command == CMD_ONCE || in_command == CMD_LOOP) begin
        res_claimed_r <= free_any ? free_idx : '0;
        res_failed_r  <= !free_any;
      end
    end
    if (st_r == S_WB) begin
      acc_r  <= acc_sum;
      vi_r   <= vi_r + VW'(1);
      last_r <= (vi_r == VW'(VOICES - 2));
      if (last_r) begin
        res_mix_r <= mix < 0 ? 8'd0 : (mix > 17'sd255 ? 8'd255 : mix[7:0]);
      end
    end
    if (out_load) begin
      out_mixed_sample  <= res_mix_r;
      out_block_end     <= res_bend_r;
      out_claimed_voice <= res_claimed_r;
      out_claim_failed  <= res_failed_r;
    end
  end

  // A stalled result stays in place until it is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_mixed_sample) && $stable(out_claimed_voice)))
    else $error("stalled result changed");
  // A tick always walks the whole voice table before finishing.
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_WB && !last_r) |=> st_r == S_RD)
    else $error("tick sweep cut short");
  // Block end is flagged only on ticks, so it never comes with a failed claim.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_block_end) |-> !out_claim_failed)
    else $error("block end on a non-tick word");
endmodule
`default_nettype wire

// File: rtl/spm_sample_ram.sv
`default_nettype none
module spm_sample_ram
  import spm_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);
  logic [7:0] mem [SAMPLE_MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/spm_voice_ram.sv
`default_nettype none
module spm_voice_ram
  import spm_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [VW-1:0] waddr,
  input  wire voice_t        wdata,
  input  wire logic [VW-1:0] raddr,
  output voice_t             rdata
);
  voice_t mem [VOICES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: bench/spm_checker.sv
`default_nettype none
module spm_checker
  import spm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [2:0]  in_command,
  input  wire logic [2:0]  in_voice,
  input  wire logic [15:0] in_address,
  input  wire logic [15:0] in_length,
  input  wire logic [15:0] in_loop_point,
  input  wire logic [15:0] in_gain,
  input  wire logic [7:0]  in_data,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [7:0]  out_mixed_sample,
  input  wire logic        out_block_end,
  input  wire logic [2:0]  out_claimed_voice,
  input  wire logic        out_claim_failed,
  output int               mismatches,
  output int               outstanding,
  output int               block_ends
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] mixed;
    logic       bend;
    logic [2:0] claimed;
    logic       failed;
  } mix_result_t;

  logic        act [VOICES];
  logic        looping [VOICES];
  logic [15:0] base [VOICES];
  logic [15:0] len [VOICES];
  logic [15:0] pos [VOICES];
  logic [15:0] restart [VOICES];
  logic [15:0] gain [VOICES];
  logic [7:0]  sample_mem [SAMPLE_MEM_DEPTH];
  int          tick_count;
  mix_result_t awaited_results[$];

  // Mixes one output sample, advances every sounding voice and, at a block end, restarts or releases ended voices.
  function automatic mix_result_t mix_tick();
    mix_result_t r;
    logic [15:0] acc;
    logic [7:0]  s;
    int          prod;
    int          level;
    r = '{mixed: 8'd128, bend: 1'b0, claimed: '0, failed: 1'b0};
    acc = '0;
    for (int v = 0; v < VOICES; v++) begin
      if (act[v] && pos[v] < len[v]) begin
        s = sample_mem[16'(base[v] + pos[v])];
        prod = (int'(s) - 128) * int'(gain[v]);
        acc = acc + 16'(prod >>> 8);
        pos[v] = pos[v] + 16'd1;
      end
    end
    level = int'($signed(acc)) + 128;
    r.mixed = (level < 0) ? 8'd0 : (level > 255) ? 8'd255 : 8'(level);
    tick_count++;
    if (tick_count >= BLOCK_LEN) begin
      tick_count = 0;
      r.bend = 1'b1;
      for (int v = 0; v < VOICES; v++) begin
        if (act[v] && pos[v] == len[v]) begin
          if (looping[v]) pos[v] = restart[v];
          else act[v] = 1'b0;
        end
      end
    end
    return r;
  endfunction

  // Applies one accepted word to the voice table or sample store and returns its result.
  function automatic mix_result_t apply_word();
    mix_result_t r;
    int          free_v;
    r = '{mixed: 8'd128, bend: 1'b0, claimed: '0, failed: 1'b0};
    case (in_command)
      CMD_TICK: r = mix_tick();
      CMD_ONCE, CMD_LOOP: begin
        free_v = -1;
        for (int v = VOICES - 1; v >= 0; v--) if (!act[v]) free_v = v;
        if (free_v < 0) begin
          r.failed = 1'b1;
        end else begin
          act[free_v] = 1'b1;
          base[free_v] = in_address;
          len[free_v] = in_length;
          pos[free_v] = '0;
          gain[free_v] = 16'd256;
          looping[free_v] = (in_command == CMD_LOOP);
          if (in_command == CMD_LOOP) restart[free_v] = in_loop_point;
          r.claimed = 3'(free_v);
        end
      end
      CMD_STOP: if (in_voice < VOICES) act[in_voice] = 1'b0;
      CMD_VOL:  if (in_voice < VOICES) gain[in_voice] = in_gain;
      CMD_WRITE: sample_mem[in_address] = in_data;
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    mix_result_t seen;
    mix_result_t want;
    if (!rst_n) begin
      for (int v = 0; v < VOICES; v++) begin
        act[v] = 1'b0; looping[v] = 1'b0; base[v] = '0; len[v] = '0;
        pos[v] = '0; restart[v] = '0; gain[v] = '0;
      end
      tick_count = 0;
      awaited_results.delete();
      mismatches = 0;
      block_ends = 0;
    end else begin
      if (in_valid && !in_stall) awaited_results.push_back(apply_word());
      if (out_valid && !out_stall) begin
        seen = '{out_mixed_sample, out_block_end, out_claimed_voice, out_claim_failed};
        if (out_block_end) block_ends++;
        if (awaited_results.size() == 0) begin
          if (mismatches < 10) $display("%t unexpected result %p", $realtime, seen);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          if (seen !== want) begin
            if (mismatches < 10)
              $display("%t result mismatch: expected %p, got %p", $realtime, want, seen);
            mismatches++;
          end
        end
      end
    end
    outstanding = awaited_results.size();
  end
endmodule
`default_nettype wire

// File: bench/testbench.sv
`default_nettype none
module testbench
  import spm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Samples are only ever played from a small window that straddles the top
  // of the address space, so that every read hits a byte written earlier and
  // the wrap of the store address is exercised along the way.
  localparam logic [15:0] WIN_BASE = 16'hFFE0;
  localparam int          WIN_LEN  = 96;
  localparam int          RANDOM_WORDS = 880;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_command = CMD_TICK;
  logic [2:0]  in_voice = '0;
  logic [15:0] in_address = '0;
  logic [15:0] in_length = '0;
  logic [15:0] in_loop_point = '0;
  logic [15:0] in_gain = '0;
  logic [7:0]  in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_mixed_sample;
  logic        out_block_end;
  logic [2:0]  out_claimed_voice;
  logic        out_claim_failed;

  int mismatches;
  int outstanding;
  int block_ends;
  int words_sent = 0;
  int ticks_sent = 0;
  int plays_sent = 0;
  bit calm = 1'b0;
  int stall_left = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  sample_playback_mixer u_top (.*);

  spm_checker u_check (.*);

  // The receiving side holds off in random bursts until the quiet last stretch.
  always @(posedge clk) begin
    if (calm || !rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 14);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Presents one word and holds it until the block takes it. The stall is
  // looked at mid-cycle, where it is settled, and the word is gone after the
  // following rising edge. Now and then the sender then idles for a burst.
  task automatic send_word(input logic [2:0] cmd, input logic [2:0] vc,
                           input logic [15:0] addr, input logic [15:0] len,
                           input logic [15:0] lp, input logic [15:0] g,
                           input logic [7:0] d);
    bit taken;
    taken = 1'b0;
    in_valid <= 1'b1;
    in_command <= cmd;
    in_voice <= vc;
    in_address <= addr;
    in_length <= len;
    in_loop_point <= lp;
    in_gain <= g;
    in_data <= d;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    words_sent++;
    if (cmd == CMD_TICK) ticks_sent++;
    if (cmd == CMD_ONCE || cmd == CMD_LOOP) plays_sent++;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // A word with every field random, for commands that ignore most of them.
  task automatic send_noisy(input logic [2:0] cmd);
    send_word(cmd, 3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 8'($urandom));
  endtask

  // Starts a sound that lies wholly inside the written window.
  task automatic play_in_window(input logic [2:0] cmd);
    int k0;
    k0 = $urandom_range(0, WIN_LEN - 1);
    send_word(cmd, 3'($urandom), WIN_BASE + 16'(k0), 16'($urandom_range(0, WIN_LEN - k0)),
              16'($urandom), 16'($urandom), 8'($urandom));
  endtask

  // A sound far longer than the window: it is started and then every voice
  // is stopped before any tick could read past what was written.
  task automatic play_long_then_silence(input logic [2:0] cmd, input logic [15:0] len);
    send_word(cmd, 3'($urandom), 16'($urandom), len, 16'($urandom), 16'($urandom),
              8'($urandom));
    for (int v = 0; v < VOICES; v++) send_word(CMD_STOP, 3'(v), '0, '0, '0, '0, '0);
  endtask

  initial begin
    int pick;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the window, with silence and both rails at its edges.
    for (int k = 0; k < WIN_LEN; k++)
      send_word(CMD_WRITE, 3'($urandom), WIN_BASE + 16'(k), 16'($urandom), 16'($urandom),
                16'($urandom), (k == 0) ? 8'd0 : (k == 1) ? 8'd255 :
                (k == WIN_LEN - 1) ? 8'd128 : 8'($urandom));

    // Directed part: unused commands, a gain stored on an idle voice, a
    // zero-length sound, a loop whose restart lies past its end, all voices
    // busy so that a claim fails, gain extremes, then a run of ticks.
    send_noisy(3'd6);
    send_noisy(3'd7);
    send_word(CMD_VOL, 3'd7, '0, '0, '0, 16'hFFFF, '0);
    send_word(CMD_STOP, 3'd7, '0, '0, '0, '0, '0);
    send_word(CMD_ONCE, '0, WIN_BASE, 16'd0, '0, '0, '0);
    send_word(CMD_LOOP, '0, WIN_BASE, 16'd4, 16'hFFFF, '0, '0);
    send_word(CMD_LOOP, '0, WIN_BASE, 16'd3, 16'd1, '0, '0);
    send_word(CMD_ONCE, '0, WIN_BASE + 16'd1, 16'd2, '0, '0, '0);
    send_word(CMD_ONCE, '0, WIN_BASE + 16'd30, 16'd40, '0, '0, '0);
    send_word(CMD_LOOP, '0, WIN_BASE, 16'(WIN_LEN), '0, '0, '0);
    send_word(CMD_ONCE, '0, WIN_BASE, 16'd8, '0, '0, '0);
    send_word(CMD_ONCE, '0, WIN_BASE, 16'd8, '0, '0, '0);
    send_word(CMD_ONCE, '0, WIN_BASE, 16'd8, '0, '0, '0);
    send_word(CMD_VOL, 3'd0, '0, '0, '0, 16'hFFFF, '0);
    send_word(CMD_VOL, 3'd1, '0, '0, '0, 16'hFFFF, '0);
    send_word(CMD_VOL, 3'd6, '0, '0, '0, 16'h0000, '0);
    for (int i = 0; i < 8; i++) send_word(CMD_TICK, '0, '0, '0, '0, '0, '0);

    // Random part: mostly ticks and well-formed plays with random content; the rest
    // stops, gain changes, writes, silenced long plays and the odd unused command.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS - 150) calm = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 45) send_noisy(CMD_TICK);
      else if (pick < 57) play_in_window(CMD_ONCE);
      else if (pick < 67) play_in_window(CMD_LOOP);
      else if (pick < 77) send_noisy(CMD_STOP);
      else if (pick < 87) send_noisy(CMD_VOL);
      else if (pick < 92) send_word(CMD_WRITE, 3'($urandom),
                                    WIN_BASE + 16'($urandom_range(0, WIN_LEN - 1)),
                                    16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
      else if (pick < 97) send_noisy(CMD_WRITE);
      else if (pick < 99) play_long_then_silence($urandom_range(0, 1) ? CMD_ONCE : CMD_LOOP,
                                                 16'($urandom) | 16'h8000);
      else send_noisy($urandom_range(0, 1) ? 3'd6 : 3'd7);
    end
    in_valid <= 1'b0;

    // Drain: wait for every awaited result or a time limit, then a little longer.
    fork
      begin
        while (outstanding != 0) @(posedge clk);
      end
      begin
        repeat (20000) @(posedge clk);
      end
    join_any
    disable fork;
    repeat (60) @(posedge clk);

    $display("Sent %0d words: %0d ticks and %0d plays, crossing %0d block ends.",
             words_sent, ticks_sent, plays_sent, block_ends);
    $display("Mismatches: %0d, results still awaited: %0d.", mismatches, outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legitimate run.
  initial begin
    #40ms;
    $display("Timed out with %0d results awaited.", outstanding);
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
`default_nettype wire
